// ----- rtl/ssc_pkg.sv -----
// Shared constants, register indexes and types for the substring search core.
package ssc_pkg;

   // Defaults for top-level parameters
   localparam int MAX_NEEDLE_DEF = 32;
   localparam int POS_BITS_DEF   = 32;

   // Needle storage and configuration port geometry
   localparam int NEEDLE_BYTES = 32;
   localparam int WORD_BYTES   = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int LEN_W        = 6;
   localparam int MATCH_POS_W  = 32;

   // Depth of the queues between front, engine and result port
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LEN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_W0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_W1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_W2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_W3  = 3'd4;

   // One result transaction
   typedef struct packed {
      logic                   found;
      logic [MATCH_POS_W-1:0] match_pos;
   } rsp_type;

endpackage

// ----- rtl/ssc_fifo.sv -----
// Small register-based FIFO with full/empty flags and simultaneous push/pop.
module ssc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ssc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/ssc_front.sv -----
// Front end: needle registers, effective length and per-byte compare vector.
module ssc_front #(
   parameter int MAX_NEEDLE = ssc_pkg::MAX_NEEDLE_DEF,
   parameter int IDX_BITS   = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration write
   input  logic                           csr_wr,
   input  logic [ssc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssc_pkg::CSR_DATA_W-1:0] csr_wdata,
   // incoming haystack byte
   input  logic [7:0]                     hay_byte,
   // classified item
   output logic                           is_term,
   output logic                           is_empty,
   output logic [IDX_BITS-1:0]            len_m1,
   output logic [MAX_NEEDLE-1:0]          eq_vec
);

   localparam int LEN_BITS   = $clog2(MAX_NEEDLE + 1);
   localparam int NEEDLE_W   = ssc_pkg::NEEDLE_BYTES * 8;
   localparam int WORD_W     = ssc_pkg::WORD_BYTES * 8;

   logic [ssc_pkg::LEN_W-1:0] needle_len_ff, needle_len_in;
   logic [NEEDLE_W-1:0]       needle_ff, needle_in;
   logic [LEN_BITS-1:0]       len_clamp;
   logic [LEN_BITS-1:0]       eff_len;

   // Register writes; unknown indexes are dropped
   always_comb begin
      needle_len_in = needle_len_ff;
      needle_in     = needle_ff;
      if (csr_wr) begin
         case (csr_index)
            ssc_pkg::CSR_NEEDLE_LEN: begin
               needle_len_in = csr_wdata[ssc_pkg::LEN_W-1:0];
            end
            ssc_pkg::CSR_NEEDLE_W0: begin
               needle_in[0*WORD_W +: WORD_W] = csr_wdata;
            end
            ssc_pkg::CSR_NEEDLE_W1: begin
               needle_in[1*WORD_W +: WORD_W] = csr_wdata;
            end
            ssc_pkg::CSR_NEEDLE_W2: begin
               needle_in[2*WORD_W +: WORD_W] = csr_wdata;
            end
            ssc_pkg::CSR_NEEDLE_W3: begin
               needle_in[3*WORD_W +: WORD_W] = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_len_ff <= '0;
         needle_ff     <= '0;
      end else begin
         needle_len_ff <= needle_len_in;
         needle_ff     <= needle_in;
      end
   end

   // Clamp length, then stop at the first zero needle byte
   always_comb begin
      if (needle_len_ff > ssc_pkg::LEN_W'(MAX_NEEDLE)) begin
         len_clamp = LEN_BITS'(MAX_NEEDLE);
      end else begin
         len_clamp = LEN_BITS'(needle_len_ff);
      end
      eff_len = len_clamp;
      for (int k = MAX_NEEDLE - 1; k >= 0; k--) begin
         if ((LEN_BITS'(k) < len_clamp) && (needle_ff[k*8 +: 8] == 8'd0)) begin
            eff_len = LEN_BITS'(k);
         end
      end
   end

   // Parallel compare of the byte against every live needle position
   always_comb begin
      for (int k = 0; k < MAX_NEEDLE; k++) begin
         eq_vec[k] = (needle_ff[k*8 +: 8] == hay_byte) && (LEN_BITS'(k) < eff_len);
      end
   end

   assign is_term  = (hay_byte == 8'd0);
   assign is_empty = (eff_len == '0);
   assign len_m1   = IDX_BITS'(eff_len - 1'b1);

endmodule

// ----- rtl/ssc_back.sv -----
// Back end: shift-and match engine with position counter and result build.
module ssc_back #(
   parameter int MAX_NEEDLE = ssc_pkg::MAX_NEEDLE_DEF,
   parameter int POS_BITS   = ssc_pkg::POS_BITS_DEF,
   parameter int IDX_BITS   = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   // classified item from the queue
   input  logic                  item_valid,
   input  logic                  is_term,
   input  logic                  is_empty,
   input  logic [IDX_BITS-1:0]   len_m1,
   input  logic [MAX_NEEDLE-1:0] eq_vec,
   output logic                  item_take,
   // result to the output queue
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output ssc_pkg::rsp_type      rsp_data
);

   localparam int DIFF_W = (POS_BITS > ssc_pkg::MATCH_POS_W) ? POS_BITS
                                                             : ssc_pkg::MATCH_POS_W;

   logic [MAX_NEEDLE-1:0] partial_hits_ff, partial_hits_in;
   logic [POS_BITS-1:0]   byte_count_ff, byte_count_in;
   logic                  reported_ff, reported_in;
   logic [MAX_NEEDLE-1:0] hits_next;
   logic [POS_BITS-1:0]   count_inc;
   logic [DIFF_W-1:0]     start_pos;
   logic                  hit;

   // Take an item only when a result slot is free
   assign item_take = item_valid && !rsp_full;

   // Shift-and step and match test on the last needle position
   assign hits_next = ((partial_hits_ff << 1) | MAX_NEEDLE'(1)) & eq_vec;
   assign hit       = hits_next[len_m1];
   assign count_inc = (byte_count_ff == '1) ? byte_count_ff : byte_count_ff + 1'b1;
   assign start_pos = DIFF_W'(byte_count_ff) - DIFF_W'(len_m1);

   // Per-transaction state update and result
   always_comb begin
      partial_hits_in = partial_hits_ff;
      byte_count_in   = byte_count_ff;
      reported_in     = reported_ff;
      rsp_push        = 1'b0;
      rsp_data        = '0;
      if (item_take) begin
         if (reported_ff) begin
            if (is_term) begin
               partial_hits_in = '0;
               byte_count_in   = '0;
               reported_in     = 1'b0;
            end
         end else if (is_empty) begin
            rsp_push       = 1'b1;
            rsp_data.found = 1'b1;
            if (is_term) begin
               partial_hits_in = '0;
               byte_count_in   = '0;
               reported_in     = 1'b0;
            end else begin
               reported_in = 1'b1;
            end
         end else if (is_term) begin
            rsp_push        = 1'b1;
            partial_hits_in = '0;
            byte_count_in   = '0;
            reported_in     = 1'b0;
         end else begin
            partial_hits_in = hits_next;
            byte_count_in   = count_inc;
            if (hit) begin
               rsp_push           = 1'b1;
               rsp_data.found     = 1'b1;
               rsp_data.match_pos = start_pos[ssc_pkg::MATCH_POS_W-1:0];
               reported_in        = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_hits_ff <= '0;
         byte_count_ff   <= '0;
         reported_ff     <= 1'b0;
      end else begin
         partial_hits_ff <= partial_hits_in;
         byte_count_ff   <= byte_count_in;
         reported_ff     <= reported_in;
      end
   end

endmodule

// ----- rtl/substring_search_core.sv -----
// Top level: streamed substring search, front classifier, item queue, engine, result queue.
//
//   channel  direction  handshake                 payload
//   req_     in         req_push / req_full       req_hay_byte[7:0]
//   rsp_     out        rsp_pop / rsp_empty       rsp_found, rsp_match_pos[31:0]
//   csr_     in         csr_valid / csr_ready     csr_index[2:0], csr_wdata[63:0]
//
// One haystack byte per cycle sustained while the result queue is not full; a result
// passes through the item queue register, a combinational engine step, then the
// result queue register before it shows on the rsp_ ports.
// The engine loop (match vector and position counter) sets the one-byte rate.
// Reset clears needle registers, engine state and both queues.
// req_full rises only when the item queue fills because the result queue is
// full and rsp_pop stays low; csr_ready is always high.
module substring_search_core #(
   parameter int MAX_NEEDLE = ssc_pkg::MAX_NEEDLE_DEF,
   parameter int POS_BITS   = ssc_pkg::POS_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // haystack input
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [7:0]                     req_hay_byte,
   // results
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic                           rsp_found,
   output logic [ssc_pkg::MATCH_POS_W-1:0] rsp_match_pos,
   // configuration
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ssc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_BITS = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
   localparam int ITEM_W   = 2 + IDX_BITS + MAX_NEEDLE;
   localparam int RSP_W    = $bits(ssc_pkg::rsp_type);

   logic                  fr_term, fr_empty;
   logic [IDX_BITS-1:0]   fr_len_m1;
   logic [MAX_NEEDLE-1:0] fr_eq;
   logic [ITEM_W-1:0]     item_wr, item_rd;
   logic                  item_q_empty, item_take;
   logic                  bk_term, bk_empty;
   logic [IDX_BITS-1:0]   bk_len_m1;
   logic [MAX_NEEDLE-1:0] bk_eq;
   logic                  rsp_q_full, rsp_push;
   ssc_pkg::rsp_type      rsp_wr, rsp_rd;

   assign csr_ready = 1'b1;

   // Front: config registers and byte classification
   ssc_front #(
      .MAX_NEEDLE (MAX_NEEDLE),
      .IDX_BITS   (IDX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .hay_byte  (req_hay_byte),
      .is_term   (fr_term),
      .is_empty  (fr_empty),
      .len_m1    (fr_len_m1),
      .eq_vec    (fr_eq)
   );

   // Item queue between front and engine
   assign item_wr = {fr_term, fr_empty, fr_len_m1, fr_eq};

   ssc_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (ssc_pkg::QUEUE_DEPTH)
   ) u_item_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (item_wr),
      .full    (req_full),
      .pop     (item_take),
      .rd_data (item_rd),
      .empty   (item_q_empty)
   );

   assign {bk_term, bk_empty, bk_len_m1, bk_eq} = item_rd;

   // Engine: shift-and update and result build
   ssc_back #(
      .MAX_NEEDLE (MAX_NEEDLE),
      .POS_BITS   (POS_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!item_q_empty),
      .is_term    (bk_term),
      .is_empty   (bk_empty),
      .len_m1     (bk_len_m1),
      .eq_vec     (bk_eq),
      .item_take  (item_take),
      .rsp_full   (rsp_q_full),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_wr)
   );

   // Result queue toward the consumer
   ssc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (ssc_pkg::QUEUE_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_q_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .empty   (rsp_empty)
   );

   assign rsp_found     = rsp_rd.found;
   assign rsp_match_pos = rsp_rd.match_pos;

endmodule
